>>> hw/rtl/pidsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID speed-to-acceleration package
// Shared types, register indexes, operation codes and controller commands.
// ----------------------------------------------------------------------------
package pidsa_pkg;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned DivSteps     = 33;   // quotient bits of the derivative divide

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_SET    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_KP    = 3'd0,
      REG_KI    = 3'd1,
      REG_KD    = 3'd2,
      REG_BOUND = 3'd3,
      REG_ACC   = 3'd4,
      REG_DEC   = 3'd5,
      REG_JERK  = 3'd6,
      REG_NONE  = 3'd7
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_SAT,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_CLAMP,
      ST_JERK,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture item
      logic div_init;  // set up divider
      logic div_step;  // one restoring step
      logic sat;       // saturate quotient
      logic mul_p;
      logic mul_i;
      logic mul_d;
      logic clamp;     // output clamp, integral commit
      logic jerk;      // rate limit, state write
      logic do_set;
      logic do_clear;
      logic reject;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       dt_zero;
      logic       div_done;
   } sts_type;

endpackage
`default_nettype wire

>>> hw/rtl/pidsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps an update through decode, divide, three multiplies, clamp and limit.
// ----------------------------------------------------------------------------
module pidsa_ctrl
   import pidsa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_fire,
   input  wire logic    out_free,
   input  sts_type      sts,
   output cmd_type      cmd,
   output logic         busy,
   output logic         done
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (in_fire) state_in = ST_DECODE;
         ST_DECODE: begin
            if (sts.op == OP_UPDATE && !sts.dt_zero) state_in = ST_DIV;
            else                                      state_in = ST_DONE;
         end
         ST_DIV:    if (sts.div_done) state_in = ST_SAT;
         ST_SAT:    state_in = ST_MUL_P;
         ST_MUL_P:  state_in = ST_MUL_I;
         ST_MUL_I:  state_in = ST_MUL_D;
         ST_MUL_D:  state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_JERK;
         ST_JERK:   state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = in_fire;
         end
         ST_DECODE: begin
            cmd.div_init = sts.op == OP_UPDATE && !sts.dt_zero;
            cmd.do_set   = sts.op == OP_SET;
            cmd.do_clear = sts.op == OP_CLEAR;
            cmd.reject   = sts.op == OP_UPDATE && sts.dt_zero;
         end
         ST_DIV:   cmd.div_step = 1'b1;
         ST_SAT:   cmd.sat      = 1'b1;
         ST_MUL_P: cmd.mul_p    = 1'b1;
         ST_MUL_I: cmd.mul_i    = 1'b1;
         ST_MUL_D: cmd.mul_d    = 1'b1;
         ST_CLAMP: cmd.clamp    = 1'b1;
         ST_JERK:  cmd.jerk     = 1'b1;
         ST_DONE:  done         = 1'b1;
         default:  busy         = 1'b1;
      endcase
   end

   // a result is shown only after the state update has completed
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_JERK |=> state_ff == ST_DONE)
      else $error("limit stage not followed by result");
   assert property (@(posedge clock) disable iff (reset)
      in_fire |-> state_ff == ST_IDLE)
      else $error("item accepted while busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !out_free |=> state_ff == ST_DONE)
      else $error("result dropped under stall");

endmodule
`default_nettype wire

>>> hw/rtl/pidsa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID datapath
// Item capture, serial divider, shared multiplier, clamps and loop state.
// ----------------------------------------------------------------------------
module pidsa_datapath
   import pidsa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  wire logic [1:0]         in_op,
   input  wire logic [15:0]        in_target,
   input  wire logic [15:0]        in_meas,
   input  wire logic [15:0]        in_dt,
   input  wire logic signed [15:0] in_applied,
   input  wire logic [15:0]        kp,
   input  wire logic [15:0]        ki,
   input  wire logic [15:0]        kd,
   input  wire logic [15:0]        bound,
   input  wire logic [14:0]        acc,
   input  wire logic [14:0]        dec,
   input  wire logic [15:0]        jerk,
   output logic signed [15:0]      accel_out,
   output logic                    rejected_out
);

   // item registers
   logic [1:0]         op_ff;
   logic [15:0]        meas_ff, dt_ff;
   logic signed [15:0] applied_ff;

   // loop state
   logic signed [39:0] integ_ff;
   logic [15:0]        last_speed_ff;
   logic               have_last_ff;
   logic signed [15:0] last_accel_ff;
   logic               rejected_ff;

   // working registers
   logic signed [16:0] err_ff;
   logic signed [39:0] cand_ff;
   logic [32:0]        quo_ff;
   logic [16:0]        rem_ff;
   logic [32:0]        num_ff;
   logic [5:0]         cnt_ff;
   logic               dneg_ff;
   logic signed [16:0] deriv_ff;
   logic signed [63:0] raw_ff;
   logic signed [16:0] a_ff;

   // combinational helpers
   logic signed [16:0] diff;
   logic [16:0]        mag;
   logic signed [39:0] sum, bnd;
   logic [17:0]        trial;
   logic signed [16:0] sq;
   logic signed [63:0] hi64, lo64, prod;
   logic signed [17:0] acc_s, dec_s;
   logic signed [17:0] lim_hi, lim_lo, aclamp;
   logic [31:0]        jprod;
   logic signed [16:0] chg;
   logic signed [40:0] fl;

   assign diff  = $signed({1'b0, in_meas}) - $signed({1'b0, last_speed_ff});
   assign mag   = diff[16] ? 17'(-diff) : diff;
   assign bnd   = $signed({8'd0, bound, 16'd0});
   assign sum   = integ_ff + 40'(err_ff * $signed({1'b0, dt_ff}));
   assign trial = {rem_ff, num_ff[32]} - {2'b0, dt_ff};
   assign acc_s = $signed({3'b0, acc});
   assign dec_s = -$signed({3'b0, dec});
   assign hi64  = 64'(acc_s) <<< 24;
   assign lo64  = 64'(dec_s) <<< 24;
   assign jprod = jerk * dt_ff;
   assign chg   = $signed({1'b0, jprod[31:16]});
   assign fl    = raw_ff[63:23] >>> 1;

   // saturated quotient
   always_comb begin
      if (!have_last_ff)         sq = '0;
      else if (dneg_ff)          sq = (quo_ff > 33'd32768) ? -17'sd32768 : 17'(-$signed(quo_ff));
      else                       sq = (quo_ff > 33'd32767) ? 17'sd32767 : 17'(quo_ff);
   end

   // shared multiplier, one product per cycle
   always_comb begin
      prod = '0;
      if (cmd.mul_p)      prod = 64'($signed({1'b0, kp}) * err_ff) <<< 16;
      else if (cmd.mul_i) prod = 64'($signed({1'b0, ki}) * cand_ff);
      else if (cmd.mul_d) prod = -(64'($signed({1'b0, kd}) * deriv_ff) <<< 16);
   end

   // rate limit window
   assign lim_hi = 18'(last_accel_ff) + 18'(chg);
   assign lim_lo = 18'(last_accel_ff) - 18'(chg);
   always_comb begin
      aclamp = 18'(a_ff);
      if (aclamp > lim_hi) aclamp = lim_hi;
      if (aclamp < lim_lo) aclamp = lim_lo;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= in_op;
         meas_ff    <= in_meas;
         dt_ff      <= in_dt;
         applied_ff <= in_applied;
         err_ff     <= $signed({1'b0, in_target}) - $signed({1'b0, in_meas});
         num_ff     <= {mag, 16'd0};
         dneg_ff    <= diff[16];
      end
      if (cmd.div_init) begin
         rem_ff  <= '0;
         quo_ff  <= '0;
         cnt_ff  <= '0;
         raw_ff  <= '0;
         if (sum > bnd)       cand_ff <= bnd;
         else if (sum < -bnd) cand_ff <= -bnd;
         else                 cand_ff <= sum;
      end
      if (cmd.div_step) begin
         if (!trial[17]) rem_ff <= trial[16:0];
         else            rem_ff <= {rem_ff[15:0], num_ff[32]};
         quo_ff <= {quo_ff[31:0], !trial[17]};
         num_ff <= {num_ff[31:0], 1'b0};
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (cmd.sat) deriv_ff <= sq;
      if (cmd.mul_p || cmd.mul_i || cmd.mul_d) raw_ff <= raw_ff + prod;
      if (cmd.clamp) begin
         if (raw_ff > hi64)      a_ff <= acc_s[16:0];
         else if (raw_ff < lo64) a_ff <= dec_s[16:0];
         else                    a_ff <= fl[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff      <= '0;
         last_speed_ff <= '0;
         have_last_ff  <= 1'b0;
         last_accel_ff <= '0;
         rejected_ff   <= 1'b0;
      end else begin
         if (cmd.load) rejected_ff <= 1'b0;
         if (cmd.reject) rejected_ff <= 1'b1;
         if (cmd.clamp && raw_ff <= hi64 && raw_ff >= lo64) integ_ff <= cand_ff;
         if (cmd.jerk) begin
            last_accel_ff <= aclamp[15:0];
            last_speed_ff <= meas_ff;
            have_last_ff  <= 1'b1;
         end
         if (cmd.do_set) begin
            if (18'(applied_ff) > acc_s)      last_accel_ff <= acc_s[15:0];
            else if (18'(applied_ff) < dec_s) last_accel_ff <= dec_s[15:0];
            else                              last_accel_ff <= applied_ff;
         end
         if (cmd.do_clear) begin
            integ_ff      <= '0;
            last_speed_ff <= '0;
            have_last_ff  <= 1'b0;
         end
      end
   end

   assign sts.op       = op_ff;
   assign sts.dt_zero  = dt_ff == 16'd0;
   assign sts.div_done = cnt_ff == 6'(DivSteps - 1) && cmd.div_step;
   assign accel_out    = last_accel_ff;
   assign rejected_out = rejected_ff;

   // stored integral never leaves its bound
   assert property (@(posedge clock) disable iff (reset)
      cmd.clamp |-> cand_ff <= bnd && cand_ff >= -bnd)
      else $error("integral candidate outside bound");
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> cnt_ff < 6'(DivSteps))
      else $error("divider overran");
   assert property (@(posedge clock) disable iff (reset)
      cmd.reject |=> rejected_ff && $stable(last_accel_ff))
      else $error("rejected item changed state");

endmodule
`default_nettype wire

>>> hw/rtl/pid_speed_to_acceleration.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID speed-to-acceleration controller
// Fixed-point speed PID with integral anti-windup and jerk limiting.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// req_      in   tdata: operation, target, measured, time step, applied accel
// rsp_      out  tdata: accel command; tuser: input rejected
// csr_      in   APB registers 0..6 at 4*i
//
// An update runs decode, the 33-step restoring derivative divide, saturate,
// the three multiplies, clamp and limit; other items go from decode to result.
// One item is in flight at a time; a stalled result holds until taken.
// Reset clears all loop state and loads register defaults.
// ----------------------------------------------------------------------------
module pid_speed_to_acceleration
   import pidsa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] operation, [17:2] target speed, [33:18] measured speed,
   // [49:34] time_step, [65:50] applied_accel, [71:66] zero
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] accel_command
   output logic [15:0]      rsp_tdata,
   // [0] input_rejected
   output logic             rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [15:0] kp_ff, ki_ff, kd_ff, bound_ff, jerk_ff;
   logic [14:0] acc_ff, dec_ff;
   reg_type     idx;
   cmd_type     cmd;
   sts_type     sts;
   logic        busy, done;
   logic signed [15:0] accel;
   logic        rej;

   assign csr_pready = 1'b1;
   assign idx        = reg_type'(csr_paddr[4:2]);

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= 16'd256; ki_ff <= '0; kd_ff <= '0; bound_ff <= 16'd1280;
         acc_ff <= 15'd512; dec_ff <= 15'd1024; jerk_ff <= 16'd512;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (idx)
            REG_KP:    kp_ff    <= csr_pwdata[15:0];
            REG_KI:    ki_ff    <= csr_pwdata[15:0];
            REG_KD:    kd_ff    <= csr_pwdata[15:0];
            REG_BOUND: bound_ff <= csr_pwdata[15:0];
            REG_ACC:   acc_ff   <= csr_pwdata[14:0];
            REG_DEC:   dec_ff   <= csr_pwdata[14:0];
            REG_JERK:  jerk_ff  <= csr_pwdata[15:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_KP:    csr_prdata = {16'd0, kp_ff};
         REG_KI:    csr_prdata = {16'd0, ki_ff};
         REG_KD:    csr_prdata = {16'd0, kd_ff};
         REG_BOUND: csr_prdata = {16'd0, bound_ff};
         REG_ACC:   csr_prdata = {17'd0, acc_ff};
         REG_DEC:   csr_prdata = {17'd0, dec_ff};
         REG_JERK:  csr_prdata = {16'd0, jerk_ff};
         default:   csr_prdata = '0;
      endcase
   end

   assign req_tready = !busy;
   assign rsp_tvalid = done;
   assign rsp_tdata  = accel;
   assign rsp_tuser  = rej;

   pidsa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (req_tvalid && req_tready),
      .out_free (rsp_tready),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy),
      .done     (done)
   );

   pidsa_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .in_op        (req_tdata[1:0]),
      .in_target    (req_tdata[17:2]),
      .in_meas      (req_tdata[33:18]),
      .in_dt        (req_tdata[49:34]),
      .in_applied   (req_tdata[65:50]),
      .kp           (kp_ff),
      .ki           (ki_ff),
      .kd           (kd_ff),
      .bound        (bound_ff),
      .acc          (acc_ff),
      .dec          (dec_ff),
      .jerk         (jerk_ff),
      .accel_out    (accel),
      .rejected_out (rej)
   );

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed PID controller testbench
// Drives control updates, set and clear items through the request stream,
// moves the gain and limit registers between phases, and compares every
// acceleration command with an in-bench fixed-point prediction.
// ----------------------------------------------------------------------------
module tb;
   import pidsa_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   typedef struct packed {
      logic [15:0] accel;
      logic        rejected;
   } command_type;

   pid_speed_to_acceleration dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor copy of registers and loop state
   longint kp, ki, kd, bound, acc_max, dec_max, jerk_max;
   longint integ, prev_speed, prev_accel;
   bit     have_speed;

   command_type commands_due[$];
   int     mismatches;
   int     updates_sent, commands_seen;
   int     idle_cycles;
   bit     random_stall;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog on cycles without any request or result handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      mismatches++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   function automatic longint floor_div24(input longint v);
      return v >>> 24;
   endfunction

   // fixed-point controller step
   function automatic command_type predict_command(input op_type op, input longint target,
                                                   input longint meas, input longint dt,
                                                   input longint applied);
      command_type c;
      longint err, lim, cand, deriv, mag, q, raw, a, chg;
      c.rejected = 1'b0;
      if (op == OP_UPDATE) begin
         if (dt == 0) begin
            c.rejected = 1'b1;
         end else begin
            err  = target - meas;
            lim  = bound * 65536;
            cand = clip(integ + err * dt, -lim, lim);
            deriv = 0;
            if (have_speed) begin
               mag = meas - prev_speed;
               if (mag < 0) mag = -mag;
               q = (mag << 16) / dt;
               if (meas < prev_speed) deriv = (q > 32768) ? -32768 : -q;
               else deriv = (q > 32767) ? 32767 : q;
            end
            raw = kp * err * 65536 + ki * cand - kd * deriv * 65536;
            if (raw > acc_max * 64'sd16777216) a = acc_max;
            else if (raw < -dec_max * 64'sd16777216) a = -dec_max;
            else begin
               a = floor_div24(raw);
               integ = cand;
            end
            chg = (jerk_max * dt) >> 16;
            a = clip(a, prev_accel - chg, prev_accel + chg);
            prev_speed = meas;
            have_speed = 1'b1;
            prev_accel = a;
         end
      end else if (op == OP_SET) begin
         prev_accel = clip(applied, -dec_max, acc_max);
      end else if (op == OP_CLEAR) begin
         integ = 0;
         prev_speed = 0;
         have_speed = 1'b0;
      end
      c.accel = prev_accel[15:0];
      return c;
   endfunction

   // valid drops only when a gap is actually taken
   task automatic sender_gap();
      int n;
      n = 0;
      if (random_stall) begin
         if ($urandom_range(0, 9) < 3) n = $urandom_range(1, 3);
         else if ($urandom_range(0, 29) == 0) n = $urandom_range(20, 90);
      end
      if (n > 0) req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // send one item and record its expected command
   task automatic send_item(input op_type op, input logic [15:0] target,
                            input logic [15:0] meas, input logic [15:0] dt,
                            input logic [15:0] applied);
      sender_gap();
      req_tdata  <= {6'd0, applied, dt, meas, target, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      commands_due.insert(commands_due.size(),
                          predict_command(op, target, meas, dt,
                                          longint'($signed(applied))));
      if (op == OP_UPDATE) updates_sent++;
   endtask

   // result side: random back-pressure and comparison
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            commands_seen++;
            if (commands_due.size() == 0) begin
               report("unexpected item", rsp_tdata, 0);
            end else begin
               if (rsp_tdata !== commands_due[0].accel)
                  report("accel_command", $signed(rsp_tdata),
                         $signed(commands_due[0].accel));
               if (rsp_tuser !== commands_due[0].rejected)
                  report("input_rejected", rsp_tuser, commands_due[0].rejected);
               void'(commands_due.pop_front());
            end
         end
         if (!random_stall) rsp_tready <= 1'b1;
         else if ($urandom_range(0, 99) == 0) rsp_tready <= 1'b0;
         else if ($urandom_range(0, 3) == 0) rsp_tready <= ~rsp_tready;
         else rsp_tready <= rsp_tready | ($urandom_range(0, 1) == 1);
      end
   end

   task automatic drain();
      req_tvalid <= 1'b0;
      while (commands_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // register write: setup then access cycle
   task automatic write_reg(input reg_type idx, input longint value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrWidth'(4 * int'(idx));
      csr_pwdata  <= 32'(value);
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_KP:    kp = value & 16'hFFFF;
         REG_KI:    ki = value & 16'hFFFF;
         REG_KD:    kd = value & 16'hFFFF;
         REG_BOUND: bound = value & 16'hFFFF;
         REG_ACC:   acc_max = value & 15'h7FFF;
         REG_DEC:   dec_max = value & 15'h7FFF;
         REG_JERK:  jerk_max = value & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_gains(input longint p, input longint i, input longint d,
                            input longint b, input longint acc, input longint dec,
                            input longint j);
      drain();
      write_reg(REG_KP, p);
      write_reg(REG_KI, i);
      write_reg(REG_KD, d);
      write_reg(REG_BOUND, b);
      write_reg(REG_ACC, acc);
      write_reg(REG_DEC, dec);
      write_reg(REG_JERK, j);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // field extremes, every operation and each special case at several settings
   task automatic test_directed();
      send_item(OP_UPDATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_item(OP_UPDATE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_item(OP_UPDATE, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF);
      send_item(OP_UPDATE, 16'h0500, 16'h0400, 16'h0100, 16'h0000);
      send_item(OP_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
      send_item(OP_SET, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
      send_item(OP_SET, 16'h0000, 16'h0000, 16'h0000, 16'h0100);
      send_item(OP_NONE, 16'h1234, 16'h5678, 16'h0000, 16'hAAAA);
      send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_UPDATE, 16'h2000, 16'h1000, 16'h8000, 16'h5555);
      drain();
      set_gains(65535, 65535, 65535, 65535, 32767, 32767, 65535);
      send_item(OP_UPDATE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_item(OP_UPDATE, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
      send_item(OP_UPDATE, 16'h8000, 16'h0000, 16'h0001, 16'h0000);
      send_item(OP_SET, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
      // zero ceilings, zero jerk freezes the command
      set_gains(256, 256, 256, 0, 0, 0, 0);
      send_item(OP_SET, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
      send_item(OP_UPDATE, 16'h3000, 16'h0100, 16'h4000, 16'h0000);
      send_item(OP_UPDATE, 16'h0100, 16'h3000, 16'h4000, 16'h0000);
   endtask

   function automatic logic [15:0] random_field();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 1023));
         default: return 16'($urandom);
      endcase
   endfunction

   // control loop runs: mostly updates with plausible speeds and steps
   task automatic test_random(input int count);
      op_type op;
      logic [15:0] t, m, dt;
      int k;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(0, 19))
            0, 1:    op = OP_SET;
            2:       op = OP_CLEAR;
            3:       op = OP_NONE;
            default: op = OP_UPDATE;
         endcase
         if ($urandom_range(0, 2) != 0) begin
            t  = 16'($urandom_range(0, 16'h2000));
            m  = 16'($urandom_range(0, 16'h2000));
            dt = 16'($urandom_range(1, 16'h0800));
         end else begin
            t = random_field(); m = random_field(); dt = random_field();
         end
         if ($urandom_range(0, 29) == 0) dt = 16'h0000;
         send_item(op, t, m, dt, random_field());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      mismatches = 0; updates_sent = 0; commands_seen = 0; idle_cycles = 0;
      random_stall = 1'b0;
      kp = 256; ki = 0; kd = 0; bound = 1280; acc_max = 512; dec_max = 1024;
      jerk_max = 512;
      integ = 0; prev_speed = 0; prev_accel = 0; have_speed = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      random_stall = 1'b1;
      set_gains(256, 64, 32, 1280, 512, 1024, 4096);
      test_random(120);
      set_gains(1024, 512, 256, 200, 2048, 3000, 65535);
      test_random(110);
      set_gains(65535, 65535, 65535, 65535, 32767, 32767, 65535);
      test_random(60);
      set_gains(0, 0, 0, 0, 1, 1, 1);
      test_random(40);
      random_stall = 1'b0;
      set_gains(400, 100, 20, 500, 800, 900, 2000);
      test_random(100);
      drain();

      $display("covered %0d updates, %0d commands checked over several register settings",
               updates_sent, commands_seen);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
